@@ design/bup_pkg.sv @@
// Shared types and constants for the box UV projection block.
// Holds field widths, register indexes, side codes and the word structs.
// No dependencies.
package bup_pkg;

	localparam int POS_WIDTH     = 24;
	localparam int POS_FRAC      = 8;
	localparam int UV_FRAC       = 16;
	localparam int NORM_WIDTH    = 16;
	localparam int CFG_IDX_WIDTH = 3;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_X  = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_Y  = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_MIN_Z  = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SIZE_X = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SIZE_Y = 3'd4;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SIZE_Z = 3'd5;

	localparam logic [2:0] SIDE_TOP    = 3'd0;
	localparam logic [2:0] SIDE_BOTTOM = 3'd1;
	localparam logic [2:0] SIDE_LEFT   = 3'd2;
	localparam logic [2:0] SIDE_RIGHT  = 3'd3;
	localparam logic [2:0] SIDE_BACK   = 3'd4;
	localparam logic [2:0] SIDE_FRONT  = 3'd5;

	typedef struct packed {
		logic signed [POS_WIDTH-1:0]  pos_x;
		logic signed [POS_WIDTH-1:0]  pos_y;
		logic signed [POS_WIDTH-1:0]  pos_z;
		logic signed [NORM_WIDTH-1:0] normal_x;
		logic signed [NORM_WIDTH-1:0] normal_y;
		logic signed [NORM_WIDTH-1:0] normal_z;
	} in_word_t;

	typedef struct packed {
		logic [UV_FRAC:0] tex_u;
		logic [UV_FRAC:0] tex_v;
		logic [2:0]       box_side;
	} out_word_t;

	typedef struct packed {
		logic signed [POS_WIDTH-1:0] min_x;
		logic signed [POS_WIDTH-1:0] min_y;
		logic signed [POS_WIDTH-1:0] min_z;
		logic [POS_WIDTH-1:0]        size_x;
		logic [POS_WIDTH-1:0]        size_y;
		logic [POS_WIDTH-1:0]        size_z;
	} cfg_t;

	typedef struct packed {
		logic [POS_WIDTH-1:0] rem;
		logic [POS_WIDTH-1:0] sz;
		logic [UV_FRAC-1:0]   quo;
		logic                 sat_zero;
		logic                 sat_one;
		logic                 flip;
	} lane_t;

	typedef struct packed {
		lane_t      u;
		lane_t      v;
		logic [2:0] side;
	} stage_t;

endpackage

@@ design/box_uv_projection.sv @@
// Top level of the box UV projection block: configuration registers and the cell chain.
// Depends on bup_pkg, bup_front, bup_cell and bup_back.
//
//   channel  direction  payload              handshake
//   in       in         in_word  (in_word_t)  in_valid / in_ready
//   out      out        out_word (out_word_t) out_valid / out_ready
//   cfg      in         cfg_index, cfg_data   cfg_valid / cfg_ready
//
// One word per cycle sustained while out_ready is high; the front stage, the chain of divider
// cells (one quotient bit per cell for both coordinates) and the back stage are all registered.
// Reset clears every stage valid and loads minima 0 and sizes 1.0.
// A stalled output holds its word; upstream stages close up bubbles, then in_ready drops.
// cfg_ready is always high; writes to indexes beyond size_z are dropped.
module box_uv_projection #(
	parameter int POS_FRAC = bup_pkg::POS_FRAC
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  bup_pkg::in_word_t                    in_word,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output bup_pkg::out_word_t                   out_word,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bup_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
	input  logic [bup_pkg::POS_WIDTH-1:0]        cfg_data
);

	localparam int NCELL = bup_pkg::UV_FRAC;
	localparam logic [bup_pkg::POS_WIDTH-1:0] SIZE_ONE =
		{{(bup_pkg::POS_WIDTH-1){1'b0}}, 1'b1} << POS_FRAC;

	bup_pkg::cfg_t   cfg_q;
	bup_pkg::stage_t chain_word [0:NCELL];
	logic            chain_valid [0:NCELL];
	logic            chain_ready [0:NCELL];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_x  <= '0;
			cfg_q.min_y  <= '0;
			cfg_q.min_z  <= '0;
			cfg_q.size_x <= SIZE_ONE;
			cfg_q.size_y <= SIZE_ONE;
			cfg_q.size_z <= SIZE_ONE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bup_pkg::REG_MIN_X:  cfg_q.min_x  <= cfg_data;
				bup_pkg::REG_MIN_Y:  cfg_q.min_y  <= cfg_data;
				bup_pkg::REG_MIN_Z:  cfg_q.min_z  <= cfg_data;
				bup_pkg::REG_SIZE_X: cfg_q.size_x <= cfg_data;
				bup_pkg::REG_SIZE_Y: cfg_q.size_y <= cfg_data;
				bup_pkg::REG_SIZE_Z: cfg_q.size_z <= cfg_data;
				default: ;
			endcase
		end
	end

	bup_front #(
		.POS_FRAC(POS_FRAC)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.up_word  (in_word),
		.dn_valid (chain_valid[0]),
		.dn_ready (chain_ready[0]),
		.dn_word  (chain_word[0])
	);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		bup_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[i]),
			.up_ready (chain_ready[i]),
			.up_word  (chain_word[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_ready (chain_ready[i+1]),
			.dn_word  (chain_word[i+1])
		);
	end

	bup_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (chain_valid[NCELL]),
		.up_ready (chain_ready[NCELL]),
		.up_word  (chain_word[NCELL]),
		.dn_valid (out_valid),
		.dn_ready (out_ready),
		.dn_word  (out_word)
	);

`ifndef SYNTHESIS
	localparam logic [bup_pkg::UV_FRAC:0] UV_ONE = {1'b1, {bup_pkg::UV_FRAC{1'b0}}};

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output register empty");

	a_uv_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.tex_u <= UV_ONE) && (out_word.tex_v <= UV_ONE))
		else $error("texture coordinate beyond 1.0");

	a_side_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.box_side <= bup_pkg::SIDE_FRONT)
		else $error("box side code out of range");
`endif

endmodule

@@ design/bup_front.sv @@
// Entry stage: picks the box side from the normal and sets up both divider lanes.
// Depends on bup_pkg.
module bup_front #(
	parameter int POS_FRAC = bup_pkg::POS_FRAC
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bup_pkg::cfg_t     cfg,
	input  logic              up_valid,
	output logic              up_ready,
	input  bup_pkg::in_word_t up_word,
	output logic              dn_valid,
	input  logic              dn_ready,
	output bup_pkg::stage_t   dn_word
);

	function automatic logic [bup_pkg::NORM_WIDTH:0] abs_n(
		input logic signed [bup_pkg::NORM_WIDTH-1:0] n
	);
		logic [bup_pkg::NORM_WIDTH:0] e;
		e = {n[bup_pkg::NORM_WIDTH-1], n};
		return e[bup_pkg::NORM_WIDTH] ? (~e + 1'b1) : e;
	endfunction

	function automatic bup_pkg::lane_t make_lane(
		input logic signed [bup_pkg::POS_WIDTH-1:0] pos,
		input logic signed [bup_pkg::POS_WIDTH-1:0] mn,
		input logic [bup_pkg::POS_WIDTH-1:0]        size,
		input logic                                 flip
	);
		logic [bup_pkg::POS_WIDTH:0]   d;
		logic [bup_pkg::POS_WIDTH-1:0] sz;
		bup_pkg::lane_t                l;
		d  = {pos[bup_pkg::POS_WIDTH-1], pos} - {mn[bup_pkg::POS_WIDTH-1], mn};
		sz = (size == '0) ? ({{(bup_pkg::POS_WIDTH-1){1'b0}}, 1'b1} << POS_FRAC) : size;
		l.rem      = d[bup_pkg::POS_WIDTH-1:0];
		l.sz       = sz;
		l.quo      = '0;
		l.sat_zero = d[bup_pkg::POS_WIDTH] || (d == '0);
		l.sat_one  = d[bup_pkg::POS_WIDTH-1:0] >= sz;
		l.flip     = flip;
		return l;
	endfunction

	logic [bup_pkg::NORM_WIDTH:0] ax, ay, az;
	logic                         px_pos, py_pos, pz_pos;
	logic [2:0]                   side;
	logic                         u_on_y, v_on_z, flip_u, flip_v;
	bup_pkg::stage_t              nxt;
	bup_pkg::stage_t              word_s1;
	logic                         valid_s1;

	always_comb begin
		ax = abs_n(up_word.normal_x);
		ay = abs_n(up_word.normal_y);
		az = abs_n(up_word.normal_z);
		px_pos = !up_word.normal_x[bup_pkg::NORM_WIDTH-1] && (up_word.normal_x != '0);
		py_pos = !up_word.normal_y[bup_pkg::NORM_WIDTH-1] && (up_word.normal_y != '0);
		pz_pos = !up_word.normal_z[bup_pkg::NORM_WIDTH-1] && (up_word.normal_z != '0);
		if (az > ax && az > ay) begin
			side = pz_pos ? bup_pkg::SIDE_TOP : bup_pkg::SIDE_BOTTOM;
		end else if (az > ax || ay > ax) begin
			side = py_pos ? bup_pkg::SIDE_RIGHT : bup_pkg::SIDE_LEFT;
		end else begin
			side = px_pos ? bup_pkg::SIDE_FRONT : bup_pkg::SIDE_BACK;
		end
		u_on_y = (side == bup_pkg::SIDE_BACK) || (side == bup_pkg::SIDE_FRONT);
		v_on_z = !((side == bup_pkg::SIDE_TOP) || (side == bup_pkg::SIDE_BOTTOM));
		flip_u = (side == bup_pkg::SIDE_BOTTOM) || (side == bup_pkg::SIDE_LEFT) ||
			(side == bup_pkg::SIDE_FRONT);
		flip_v = v_on_z;
		nxt.side = side;
		nxt.u = u_on_y ? make_lane(up_word.pos_y, cfg.min_y, cfg.size_y, flip_u)
			: make_lane(up_word.pos_x, cfg.min_x, cfg.size_x, flip_u);
		nxt.v = v_on_z ? make_lane(up_word.pos_z, cfg.min_z, cfg.size_z, flip_v)
			: make_lane(up_word.pos_y, cfg.min_y, cfg.size_y, flip_v);
	end

	assign up_ready = !valid_s1 || dn_ready;
	assign dn_valid = valid_s1;
	assign dn_word  = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_s1 <= nxt;
		end
	end

endmodule

@@ design/bup_cell.sv @@
// Divider cell: one restoring quotient bit for each of the two lanes per stage.
// Depends on bup_pkg.
module bup_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  bup_pkg::stage_t up_word,
	output logic            dn_valid,
	input  logic            dn_ready,
	output bup_pkg::stage_t dn_word
);

	function automatic bup_pkg::lane_t step(input bup_pkg::lane_t l);
		logic [bup_pkg::POS_WIDTH:0] t;
		logic [bup_pkg::POS_WIDTH:0] diff;
		logic                        bit_q;
		bup_pkg::lane_t              r;
		t     = {l.rem, 1'b0};
		diff  = t - {1'b0, l.sz};
		bit_q = t >= {1'b0, l.sz};
		r     = l;
		r.rem = bit_q ? diff[bup_pkg::POS_WIDTH-1:0] : t[bup_pkg::POS_WIDTH-1:0];
		r.quo = {l.quo[bup_pkg::UV_FRAC-2:0], bit_q};
		return r;
	endfunction

	bup_pkg::stage_t nxt;
	bup_pkg::stage_t word_s1;
	logic            valid_s1;

	always_comb begin
		nxt      = up_word;
		nxt.u    = step(up_word.u);
		nxt.v    = step(up_word.v);
	end

	assign up_ready = !valid_s1 || dn_ready;
	assign dn_valid = valid_s1;
	assign dn_word  = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_s1 <= nxt;
		end
	end

endmodule

@@ design/bup_back.sv @@
// Output stage: applies saturation and side flips, then holds the result word.
// Depends on bup_pkg.
module bup_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  bup_pkg::stage_t    up_word,
	output logic               dn_valid,
	input  logic               dn_ready,
	output bup_pkg::out_word_t dn_word
);

	localparam logic [bup_pkg::UV_FRAC:0] ONE = {1'b1, {bup_pkg::UV_FRAC{1'b0}}};

	function automatic logic [bup_pkg::UV_FRAC:0] finish(input bup_pkg::lane_t l);
		logic [bup_pkg::UV_FRAC:0] q;
		if (l.sat_zero) begin
			q = '0;
		end else if (l.sat_one) begin
			q = ONE;
		end else begin
			q = {1'b0, l.quo};
		end
		return l.flip ? (ONE - q) : q;
	endfunction

	bup_pkg::out_word_t nxt;
	bup_pkg::out_word_t word_s1;
	logic               valid_s1;

	always_comb begin
		nxt.tex_u    = finish(up_word.u);
		nxt.tex_v    = finish(up_word.v);
		nxt.box_side = up_word.side;
	end

	assign up_ready = !valid_s1 || dn_ready;
	assign dn_valid = valid_s1;
	assign dn_word  = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			word_s1 <= nxt;
		end
	end

endmodule
